### hdl/one_wire_bus_master_unit_macros.svh
// assertion macros used by the 1-wire bus master rtl
`ifndef ONE_WIRE_BUS_MASTER_UNIT_MACROS_SVH
`define ONE_WIRE_BUS_MASTER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define OWM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define OWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/owm_pkg.sv
// types, codes and slot timing for the 1-wire bus master
package owm_pkg;

    localparam int TICK_W = 9;
    localparam int BYTE_W = 8;
    localparam int BITS_W = 4;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_RESET = 3'd1,
        OP_WBIT  = 3'd2,
        OP_RBIT  = 3'd3,
        OP_WBYTE = 3'd4,
        OP_RBYTE = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LOW  = 2'd1,
        PH_REL  = 2'd2
    } phase_t;

    typedef logic [TICK_W-1:0] tick_t;

    // slot timing in ticks
    localparam tick_t RST_LOW_LEN    = tick_t'(480);
    localparam tick_t RST_SAMPLE_AT  = tick_t'(70);
    localparam tick_t RST_REL_LEN    = tick_t'(70 + 410);
    localparam tick_t W1_LOW_LEN     = tick_t'(10);
    localparam tick_t W1_REL_LEN     = tick_t'(55 + 5);
    localparam tick_t W0_LOW_LEN     = tick_t'(65);
    localparam tick_t W0_REL_LEN     = tick_t'(5);
    localparam tick_t RD_LOW_LEN     = tick_t'(3);
    localparam tick_t RD_SAMPLE_AT   = tick_t'(10);
    localparam tick_t RD_REL_LEN     = tick_t'(10 + 50);
    localparam tick_t NO_SAMPLE      = tick_t'(0);
    localparam logic [BITS_W-1:0] BITS_BYTE = BITS_W'(8);
    localparam logic [BITS_W-1:0] BITS_ONE  = BITS_W'(1);

    typedef struct packed {
        logic [2:0]        req_type;
        logic [BYTE_W-1:0] data_value;
        logic              bus_level;
    } req_t;

    typedef struct packed {
        logic              drive_low;
        logic              busy_res;
        logic              done_res;
        logic              presence;
        logic [BYTE_W-1:0] read_data;
    } res_t;

    function automatic logic is_read_op(input op_t op);
        is_read_op = (op == OP_RBIT) || (op == OP_RBYTE);
    endfunction

    function automatic logic is_write_op(input op_t op);
        is_write_op = (op == OP_WBIT) || (op == OP_WBYTE);
    endfunction

    function automatic tick_t low_len(input op_t op, input logic bit0);
        if (op == OP_RESET)
            low_len = RST_LOW_LEN;
        else if (is_read_op(op))
            low_len = RD_LOW_LEN;
        else
            low_len = bit0 ? W1_LOW_LEN : W0_LOW_LEN;
    endfunction

    function automatic tick_t rel_len(input op_t op, input logic bit0);
        if (op == OP_RESET)
            rel_len = RST_REL_LEN;
        else if (is_read_op(op))
            rel_len = RD_REL_LEN;
        else
            rel_len = bit0 ? W1_REL_LEN : W0_REL_LEN;
    endfunction

    function automatic tick_t sample_at(input op_t op);
        if (op == OP_RESET)
            sample_at = RST_SAMPLE_AT;
        else if (is_read_op(op))
            sample_at = RD_SAMPLE_AT;
        else
            sample_at = NO_SAMPLE;
    endfunction

endpackage

### hdl/owm_if.sv
// request and result channel interfaces of the 1-wire bus master
interface owm_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] req_type;
    logic [7:0] data_value;
    logic       bus_level;

    modport source (output valid, req_type, data_value, bus_level, input ready);
    modport sink (input valid, req_type, data_value, bus_level, output ready);
endinterface

interface owm_res_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;

    modport source (output valid, drive_low, busy_res, done_res, presence, read_data,
                    input ready);
    modport sink (input valid, drive_low, busy_res, done_res, presence, read_data,
                  output ready);
endinterface

### hdl/one_wire_bus_master_unit.sv
// 1-wire bus master: tick-timed reset, bit and byte slots
// usage:
//   req carries one item per handshake: a tick (req_type 0, bus_level is the
//   sampled line) or a command (reset, write bit, read bit, write byte, read
//   byte). a command is taken only when no slot is running; otherwise it is
//   dropped and does not count as a tick. codes 6 and 7 are ignored.
//   res returns exactly one item per request item, in order: drive_low (pull
//   the line low when 1, release it when 0), busy, done on the finishing tick,
//   the latched presence bit and the last read result.
// timing:
//   an accepted item lands in the input register; when it advances, the slot
//   state machine and the result register update together from it, so the
//   result is registered behind the input register. throughput is one item
//   per clock while res.ready keeps the result register moving.
// reset:
//   rst_n clears the valid bits of both pipeline registers and the slot
//   state: idle, no presence, read result zero.
// stall:
//   while res.ready is low the result register holds; the input register
//   still takes one more item, then req.ready drops until the result moves.
`include "one_wire_bus_master_unit_macros.svh"

module one_wire_bus_master_unit (
    input  logic     clk,
    input  logic     rst_n,
    owm_req_if.sink  req,
    owm_res_if.source res
);
    import owm_pkg::*;

    // pipeline registers
    logic   in_valid_reg;
    req_t   in_item_reg;
    logic   out_valid_reg, out_valid_next;
    res_t   out_item_reg, out_item_next;
    logic   advance;
    logic   req_take;

    // slot state
    phase_t            phase_reg, phase_next;
    op_t               op_kind_reg, op_kind_next;
    tick_t             tick_count_reg, tick_count_next;
    logic [BITS_W-1:0] bits_left_reg, bits_left_next;
    logic [BYTE_W-1:0] shift_byte_reg, shift_byte_next;
    logic              presence_reg, presence_next;
    logic [BYTE_W-1:0] read_data_reg, read_data_next;

    // decoded conditions
    op_t               cur_op;
    logic              is_tick;
    logic              is_start;
    tick_t             tick_inc;
    logic              low_end;
    logic              sample_hit;
    logic              rel_end;
    logic              more_bits;
    logic [BYTE_W-1:0] shift_sampled;
    logic              done_now;

    // pipeline moves when the result register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || res.ready);
    assign req.ready = !in_valid_reg || advance;
    assign req_take  = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            in_item_reg.req_type   <= req.req_type;
            in_item_reg.data_value <= req.data_value;
            in_item_reg.bus_level  <= req.bus_level;
        end
    end

    // request decode and slot timing conditions
    always_comb
    begin
        cur_op     = op_t'(in_item_reg.req_type);
        is_tick    = advance && (cur_op == OP_TICK) && (phase_reg != PH_IDLE);
        is_start   = 1'b0;
        case (cur_op)
            OP_RESET, OP_WBIT, OP_RBIT, OP_WBYTE, OP_RBYTE:
                is_start = advance && (phase_reg == PH_IDLE);
            default:
                is_start = 1'b0;
        endcase
        tick_inc   = tick_count_reg + tick_t'(1);
        low_end    = tick_inc >= low_len(op_kind_reg, shift_byte_reg[0]);
        sample_hit = tick_inc == sample_at(op_kind_reg);
        rel_end    = tick_inc >= rel_len(op_kind_reg, shift_byte_reg[0]);
        more_bits  = bits_left_reg > BITS_ONE;
        done_now   = is_tick && (phase_reg == PH_REL) && rel_end && !more_bits;
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE:
                if (is_start)
                    phase_next = PH_LOW;
            PH_LOW:
                if (is_tick && low_end)
                    phase_next = PH_REL;
            PH_REL:
                if (is_tick && rel_end)
                    phase_next = more_bits ? PH_LOW : PH_IDLE;
            default:
                phase_next = PH_IDLE;
        endcase
    end

    // slot datapath: counter, shifter, presence and read result
    always_comb
    begin
        op_kind_next    = op_kind_reg;
        tick_count_next = tick_count_reg;
        bits_left_next  = bits_left_reg;
        shift_byte_next = shift_byte_reg;
        presence_next   = presence_reg;
        read_data_next  = read_data_reg;
        shift_sampled   = shift_byte_reg;

        // read slots shift in lsb first from the top
        if ((phase_reg == PH_REL) && sample_hit && is_read_op(op_kind_reg))
            shift_sampled = {in_item_reg.bus_level, shift_byte_reg[BYTE_W-1:1]};

        if (is_start)
        begin
            op_kind_next    = cur_op;
            tick_count_next = '0;
            bits_left_next  = ((cur_op == OP_WBYTE) || (cur_op == OP_RBYTE)) ?
                              BITS_BYTE : BITS_ONE;
            case (cur_op)
                OP_WBIT:  shift_byte_next = {{(BYTE_W-1){1'b0}}, in_item_reg.data_value[0]};
                OP_WBYTE: shift_byte_next = in_item_reg.data_value;
                default:  shift_byte_next = '0;
            endcase
        end
        else if (is_tick)
        begin
            tick_count_next = tick_inc;
            if (phase_reg == PH_LOW)
            begin
                if (low_end)
                    tick_count_next = '0;
            end
            else
            begin
                // presence is an active-low answer
                if (sample_hit && (op_kind_reg == OP_RESET))
                    presence_next = !in_item_reg.bus_level;
                shift_byte_next = shift_sampled;
                if (rel_end)
                begin
                    if (is_write_op(op_kind_reg))
                        shift_byte_next = shift_sampled >> 1;
                    tick_count_next = '0;
                    if (more_bits)
                    begin
                        bits_left_next = bits_left_reg - BITS_ONE;
                    end
                    else
                    begin
                        bits_left_next = '0;
                        if (op_kind_reg == OP_RBIT)
                            read_data_next = {{(BYTE_W-1){1'b0}}, shift_sampled[BYTE_W-1]};
                        else if (op_kind_reg == OP_RBYTE)
                            read_data_next = shift_sampled;
                    end
                end
            end
        end
    end

    // result register contents
    always_comb
    begin
        out_item_next.drive_low = phase_next == PH_LOW;
        out_item_next.busy_res  = phase_next != PH_IDLE;
        out_item_next.done_res  = done_now;
        out_item_next.presence  = presence_next;
        out_item_next.read_data = read_data_next;
        if (advance)
            out_valid_next = 1'b1;
        else if (res.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            phase_reg      <= PH_IDLE;
            op_kind_reg    <= OP_TICK;
            tick_count_reg <= '0;
            bits_left_reg  <= '0;
            shift_byte_reg <= '0;
            presence_reg   <= 1'b0;
            read_data_reg  <= '0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            phase_reg      <= phase_next;
            op_kind_reg    <= op_kind_next;
            tick_count_reg <= tick_count_next;
            bits_left_reg  <= bits_left_next;
            shift_byte_reg <= shift_byte_next;
            presence_reg   <= presence_next;
            read_data_reg  <= read_data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_item_reg <= out_item_next;
    end

    assign res.valid     = out_valid_reg;
    assign res.drive_low = out_item_reg.drive_low;
    assign res.busy_res  = out_item_reg.busy_res;
    assign res.done_res  = out_item_reg.done_res;
    assign res.presence  = out_item_reg.presence;
    assign res.read_data = out_item_reg.read_data;

    // checks
    `OWM_ASSERT_NOW(a_idle_no_bits, clk, rst_n,
        phase_reg == PH_IDLE, bits_left_reg == '0, "idle with bits left")
    `OWM_ASSERT_NOW(a_bits_bound, clk, rst_n,
        phase_reg != PH_IDLE, (bits_left_reg != '0) && (bits_left_reg <= BITS_BYTE),
        "bit count out of range while busy")
    `OWM_ASSERT_NOW(a_tick_bound, clk, rst_n,
        1'b1, tick_count_reg < RST_REL_LEN, "slot counter past longest slot")
    `OWM_ASSERT_NEXT(a_item_kept, clk, rst_n,
        in_valid_reg && !advance, in_valid_reg, "input item dropped while stalled")
    `OWM_ASSERT_NOW(a_done_idle, clk, rst_n,
        res.valid && res.done_res, !res.busy_res && !res.drive_low,
        "done reported with slot still running")

endmodule
